### hw/rtl/rtcc_pkg.sv
// Shared types, register map and BCD calendar helpers for the RTC register unit.
// No dependencies; imported by rtcc_tick and rtc_calendar_registers_unit.
`default_nettype none

package rtcc_pkg;

   localparam int unsigned TimeRegCount = 7;

   typedef logic [7:0] reg8_type;
   typedef logic [TimeRegCount-1:0][7:0] time_regs_type;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam reg8_type ADDR_SEC   = 8'h00;
   localparam reg8_type ADDR_MIN   = 8'h01;
   localparam reg8_type ADDR_HOUR  = 8'h02;
   localparam reg8_type ADDR_WEEK  = 8'h03;
   localparam reg8_type ADDR_DAY   = 8'h04;
   localparam reg8_type ADDR_MONTH = 8'h05;
   localparam reg8_type ADDR_YEAR  = 8'h06;
   localparam reg8_type ADDR_CTR1  = 8'h0F;
   localparam reg8_type ADDR_CTR2  = 8'h10;

   localparam reg8_type WEN_CTR2 = 8'h80;
   localparam reg8_type WEN_CTR1 = 8'h84;
   localparam reg8_type CTR2_LOW = 8'h0F;
   localparam reg8_type HOUR_24H = 8'h80;

   // bits that exist in each time register, second first
   localparam reg8_type STORE_MASK [TimeRegCount] = '{
      8'h7F, 8'h7F, 8'hBF, 8'h07, 8'h3F, 8'h1F, 8'hFF
   };

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // year 00, month 01, day 01, weekday 0, 00:00:00 (index 0 is seconds)
   localparam time_regs_type TIME_RESET = {
      8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // high nibble * 10 + low nibble, at most 165
   function automatic reg8_type from_bcd(input reg8_type v);
      return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'h0, v[3:0]};
   endfunction

   // tens by reciprocal (205 / 2048), tens digit truncated to a nibble
   function automatic reg8_type to_bcd(input reg8_type v);
      logic [15:0] prod;
      logic [4:0]  tens;
      reg8_type    tens10;
      reg8_type    ones;
      prod   = {8'h00, v} * 16'd205;
      tens   = prod[15:11];
      tens10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
      ones   = v - tens10;
      return {tens[3:0], ones[3:0]};
   endfunction

   // year 2000+yy: leap when yy divisible by 4, except 2100
   function automatic logic [4:0] month_days(input reg8_type yy, input reg8_type mo);
      if (mo < 8'd1 || mo > 8'd12) begin
         return 5'd0;
      end
      if (mo == 8'd2 && yy[1:0] == 2'b00 && yy != 8'd100) begin
         return 5'd29;
      end
      return MONTH_LEN[mo[3:0] - 4'd1];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rtcc_tick.sv
// One-second calendar advance: decodes the BCD time registers, carries
// through second..year and re-encodes. Depends on rtcc_pkg.
`default_nettype none

module rtcc_tick
   import rtcc_pkg::*;
(
   input  time_regs_type cur_time,
   output time_regs_type next_time
);

   reg8_type   s, mi, h, w, d, mo, y;
   reg8_type   s_n, mi_n, h_n, w_n, d_n, mo_n, y_n;
   logic [4:0] mdays;

   always_comb begin
      s  = from_bcd(cur_time[0] & 8'h7F);
      mi = from_bcd(cur_time[1] & 8'h7F);
      h  = from_bcd(cur_time[2] & 8'h3F);
      w  = from_bcd(cur_time[3] & 8'h07);
      d  = from_bcd(cur_time[4] & 8'h3F);
      mo = from_bcd(cur_time[5] & 8'h1F);
      y  = from_bcd(cur_time[6]);
      mdays = month_days(y, mo);

      s_n = s; mi_n = mi; h_n = h; w_n = w; d_n = d; mo_n = mo; y_n = y;

      if (s < 8'd59) begin
         s_n = s + 8'd1;
      end else begin
         s_n = 8'd0;
         if (mi < 8'd59) begin
            mi_n = mi + 8'd1;
         end else begin
            mi_n = 8'd0;
            if (h < 8'd23) begin
               h_n = h + 8'd1;
            end else begin
               h_n = 8'd0;
               w_n = (w < 8'd6) ? w + 8'd1 : 8'd0;
               if (d < {3'b000, mdays}) begin
                  d_n = d + 8'd1;
               end else begin
                  d_n = 8'd1;
                  if (mo < 8'd12) begin
                     mo_n = mo + 8'd1;
                  end else begin
                     mo_n = 8'd1;
                     y_n  = (y < 8'd99) ? y + 8'd1 : 8'd0;
                  end
               end
            end
         end
      end

      // every field is re-encoded, so out-of-range digits normalize here
      next_time[0] = to_bcd(s_n);
      next_time[1] = to_bcd(mi_n);
      next_time[2] = to_bcd(h_n) | (cur_time[2] & HOUR_24H);
      next_time[3] = to_bcd(w_n);
      next_time[4] = to_bcd(d_n);
      next_time[5] = to_bcd(mo_n);
      next_time[6] = to_bcd(y_n);
   end

endmodule

`default_nettype wire

### hw/rtl/rtc_calendar_registers_unit.sv
// RTC calendar register unit: input register, register access / tick logic,
// result register. rsp_tvalid rises when an accepted item moves on from the input
// register into the result register, which also updates the calendar state.
// Throughput 1 item per cycle unless a result is held waiting on rsp_tready.
// Synchronous active-high reset: empty pipeline, time 2000-01-01 00:00:00,
// weekday 0, CTR1 and CTR2 zero.
`default_nettype none

module rtc_calendar_registers_unit
   import rtcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] reg_addr, [15:8] write_data
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic [0:0]  rsp_tuser    // [0] write_blocked
);

   logic          s1_valid_ff, s1_valid_in;
   opcode_type    s1_op_ff;
   reg8_type      s1_addr_ff, s1_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   reg8_type      rsp_data_ff, rsp_data_in;
   logic          rsp_blocked_ff, rsp_blocked_in;
   time_regs_type time_ff, time_in;
   reg8_type      ctr1_ff, ctr1_in;
   reg8_type      ctr2_ff, ctr2_in;

   time_regs_type tick_time;
   logic          out_adv;
   logic          s1_fire;
   logic          req_fire;
   logic          wr_en;
   reg8_type      ctr1_setting;

   rtcc_tick u_tick (
      .cur_time  (time_ff),
      .next_time (tick_time)
   );

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && out_adv;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_adv);
   assign rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;

   assign wr_en = ctr2_ff[7] && ((ctr1_ff & WEN_CTR1) == WEN_CTR1);
   assign ctr1_setting = s1_data_ff & WEN_CTR1 & ~ctr1_ff;

   always_comb begin
      time_in        = time_ff;
      ctr1_in        = ctr1_ff;
      ctr2_in        = ctr2_ff;
      rsp_data_in    = 8'h00;
      rsp_blocked_in = 1'b0;
      unique case (s1_op_ff)
         OP_READ: begin
            if (s1_addr_ff <= ADDR_YEAR) begin
               rsp_data_in = time_ff[s1_addr_ff[2:0]];
            end else if (s1_addr_ff == ADDR_CTR1) begin
               rsp_data_in = ctr1_ff;
            end else if (s1_addr_ff == ADDR_CTR2) begin
               rsp_data_in = ctr2_ff;
            end
         end
         OP_WRITE: begin
            if (s1_addr_ff <= ADDR_YEAR) begin
               if (wr_en) begin
                  time_in[s1_addr_ff[2:0]] = s1_data_ff & STORE_MASK[s1_addr_ff[2:0]];
               end else begin
                  rsp_blocked_in = 1'b1;
               end
            end else if (s1_addr_ff == ADDR_CTR1) begin
               if (ctr2_ff[7]) begin
                  ctr1_in = s1_data_ff;
               end else begin
                  // enable bits may be cleared but not set while CTR2 bit7 is low
                  rsp_blocked_in = (ctr1_setting != 8'h00);
                  ctr1_in = (s1_data_ff & ~WEN_CTR1) | (s1_data_ff & ctr1_ff & WEN_CTR1);
               end
            end else if (s1_addr_ff == ADDR_CTR2) begin
               if (wr_en) begin
                  ctr2_in = s1_data_ff;
               end else begin
                  rsp_blocked_in = ((s1_data_ff & CTR2_LOW) != (ctr2_ff & CTR2_LOW));
                  ctr2_in = (s1_data_ff & ~CTR2_LOW) | (ctr2_ff & CTR2_LOW);
               end
            end
         end
         OP_TICK: begin
            time_in = tick_time;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= TIME_RESET;
         ctr1_ff      <= 8'h00;
         ctr2_ff      <= 8'h00;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            time_ff <= time_in;
            ctr1_ff <= ctr1_in;
            ctr2_ff <= ctr2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= opcode_type'(req_tuser);
         s1_addr_ff <= req_tdata[7:0];
         s1_data_ff <= req_tdata[15:8];
      end
      if (s1_fire) begin
         rsp_data_ff    <= rsp_data_in;
         rsp_blocked_ff <= rsp_blocked_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_blocked_ff;

endmodule

`default_nettype wire

### hw/rtl/rtcc_checker.sv
// Port-level checks for rtc_calendar_registers_unit, attached by bind.
// No package dependencies.
`default_nettype none

module rtcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a result waiting to be taken stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before the item was taken");

   // a dropped write never carries read data
   a_blocked_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("write_blocked item with nonzero read_data");

   // input side only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output back-pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind rtc_calendar_registers_unit rtcc_checker u_rtcc_checker (.*);

`default_nettype wire
